/* rtl/core/bidalloc_pkg.sv */
// shared types and constants of the context-id bitmap allocator
// no dependencies; used by bidalloc_dp, bidalloc_ctrl and the top level
`timescale 1ns / 1ps

package bidalloc_pkg;

    localparam int ID_W       = 16;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int WORD_BITS  = 64;
    localparam int GROUP_BITS = 8;

    localparam int DEF_MAX_IDS           = 256;
    localparam int DEF_RESERVED_COUNT    = 1;
    localparam int DEF_SHARED_COUNT_BITS = 32;

    localparam logic [CMD_W-1:0] CMD_ALLOC_PRIVATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC_SHARED  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE          = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_PRESENT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_WIDTH_M1     = 1'd1;

    typedef enum logic [2:0] {
        RES_INVALID,
        RES_TRIVIAL,
        RES_NO_FREE,
        RES_SATURATED,
        RES_SHARED_ALLOC,
        RES_SHARED_FREE,
        RES_PRIV_ALLOC,
        RES_PRIV_FREE
    } res_sel_t;

    typedef enum logic [1:0] {
        WOP_HOLD,
        WOP_CLEAR,
        WOP_INC,
        WOP_FROM_ID
    } word_op_t;

    typedef enum logic [1:0] {
        WR_INIT,
        WR_SET,
        WR_CLR
    } wr_sel_t;

    typedef struct packed {
        word_op_t word_op;
        logic     latch_id;
        logic     mem_rd;
        logic     mem_wr;
        wr_sel_t  wr_sel;
        logic     mask_load;
        logic     result_load;
        res_sel_t res_sel;
    } ctl_cmd_t;

    typedef struct packed {
        logic cmd_alloc_priv;
        logic cmd_alloc_shared;
        logic cmd_free;
        logic feature;
        logic shared_full;
        logic shared_zero;
        logic id_is_shared;
        logic id_in_range;
        logic found;
        logic scan_last;
        logic init_last;
    } ctl_stat_t;

endpackage

/* rtl/core/bidalloc_dp.sv */
// datapath: config registers, bitmap word memory, free-bit search, shared count, result
// depends on bidalloc_pkg
`timescale 1ns / 1ps

module bidalloc_dp #(
    parameter int MAX_IDS           = bidalloc_pkg::DEF_MAX_IDS,
    parameter int RESERVED_COUNT    = bidalloc_pkg::DEF_RESERVED_COUNT,
    parameter int SHARED_COUNT_BITS = bidalloc_pkg::DEF_SHARED_COUNT_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [bidalloc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bidalloc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [bidalloc_pkg::CMD_W-1:0]       command,
    input  logic [bidalloc_pkg::ID_W-1:0]        id,
    input  bidalloc_pkg::ctl_cmd_t               ctl,
    output bidalloc_pkg::ctl_stat_t              stat,
    output logic [bidalloc_pkg::STATUS_W-1:0]    status,
    output logic [bidalloc_pkg::ID_W-1:0]        result_id,
    output logic                                 refresh_request,
    output logic                                 refresh_is_release
);

    localparam int ID_W       = bidalloc_pkg::ID_W;
    localparam int WORD_BITS  = bidalloc_pkg::WORD_BITS;
    localparam int GROUP_BITS = bidalloc_pkg::GROUP_BITS;
    localparam int NUM_WORDS  = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_AW     = $clog2(WORD_BITS);
    localparam int NUM_GROUPS = WORD_BITS / GROUP_BITS;
    localparam int GRP_AW     = $clog2(NUM_GROUPS);
    localparam int GBIT_AW    = $clog2(GROUP_BITS);

    localparam logic [ID_W-1:0]      MAX_ID     = ID_W'(MAX_IDS - 1);
    localparam logic [ID_W-1:0]      SHARED_ID  = ID_W'(RESERVED_COUNT);
    localparam logic [ID_W-1:0]      PRIV_START = ID_W'(RESERVED_COUNT + 1);
    localparam logic [BIT_AW-1:0]    PS_BIT     = BIT_AW'(RESERVED_COUNT + 1);
    localparam logic [WORD_AW-1:0]   LAST_WORD  = WORD_AW'(NUM_WORDS - 1);
    localparam logic [WORD_BITS-1:0] INIT_WORD  = WORD_BITS'((1 << (RESERVED_COUNT + 1)) - 1);

    logic                         feature_reg;
    logic [3:0]                   width_reg;
    logic [SHARED_COUNT_BITS-1:0] count_reg;
    logic [SHARED_COUNT_BITS-1:0] count_next;
    logic [WORD_AW-1:0]           word_cnt_reg;
    logic [WORD_AW-1:0]           word_cnt_next;
    logic [ID_W-1:0]              id_reg;
    logic [WORD_BITS-1:0]         rd_data_reg;
    logic [WORD_BITS-1:0]         free_reg;
    logic [WORD_BITS-1:0]         free_next;
    logic [NUM_GROUPS-1:0]        grp_reg;
    logic [NUM_GROUPS-1:0]        grp_next;
    logic [WORD_BITS-1:0]         bitmap_mem [NUM_WORDS];
    logic [WORD_BITS-1:0]         wr_data;

    logic [bidalloc_pkg::STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]              result_id_reg;
    logic                         refresh_request_reg;
    logic                         refresh_is_release_reg;

    logic [ID_W-1:0]              top_raw;
    logic [ID_W-1:0]              top;
    logic [WORD_AW-1:0]           last_word;
    logic [BIT_AW-1:0]            top_bit;
    logic [GRP_AW-1:0]            pick_grp;
    logic [GROUP_BITS-1:0]        pick_byte;
    logic [GBIT_AW-1:0]           pick_gbit;
    logic [BIT_AW-1:0]            pick_bit;
    logic [ID_W-1:0]              pick_id;

    // highest usable id: 2^(width_reg + 1) - 1, clamped to the store
    assign top_raw   = {ID_W{1'b1}} >> (4'd15 - width_reg);
    assign top       = (top_raw > MAX_ID) ? MAX_ID : top_raw;
    assign last_word = WORD_AW'(top >> BIT_AW);
    assign top_bit   = top[BIT_AW-1:0];

    // free bits of the current word inside [private start, top]
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            free_next[b] = ~rd_data_reg[b]
                & ((word_cnt_reg != '0) || (BIT_AW'(b) >= PS_BIT))
                & ((word_cnt_reg != last_word) || (BIT_AW'(b) <= top_bit));
        end
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_next[g] = |free_next[g*GROUP_BITS +: GROUP_BITS];
        end
    end

    // two-level lowest-set search over the registered free mask
    always_comb
    begin
        pick_grp = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (grp_reg[g])
            begin
                pick_grp = GRP_AW'(g);
            end
        end
        pick_byte = free_reg[pick_grp*GROUP_BITS +: GROUP_BITS];
        pick_gbit = '0;
        for (int k = GROUP_BITS - 1; k >= 0; k--)
        begin
            if (pick_byte[k])
            begin
                pick_gbit = GBIT_AW'(k);
            end
        end
    end

    assign pick_bit = {pick_grp, pick_gbit};
    assign pick_id  = ID_W'({word_cnt_reg, pick_bit});

    always_comb
    begin
        case (ctl.wr_sel)
            bidalloc_pkg::WR_INIT: wr_data = (word_cnt_reg == '0) ? INIT_WORD : '0;
            bidalloc_pkg::WR_SET:  wr_data = rd_data_reg | (WORD_BITS'(1) << pick_bit);
            bidalloc_pkg::WR_CLR:  wr_data = rd_data_reg
                                             & ~(WORD_BITS'(1) << id_reg[BIT_AW-1:0]);
            default:               wr_data = rd_data_reg;
        endcase
    end

    always_comb
    begin
        case (ctl.word_op)
            bidalloc_pkg::WOP_CLEAR:   word_cnt_next = '0;
            bidalloc_pkg::WOP_INC:     word_cnt_next = word_cnt_reg + 1'b1;
            bidalloc_pkg::WOP_FROM_ID: word_cnt_next = WORD_AW'(id >> BIT_AW);
            default:                   word_cnt_next = word_cnt_reg;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.result_load)
        begin
            case (ctl.res_sel)
                bidalloc_pkg::RES_SHARED_ALLOC: count_next = count_reg + 1'b1;
                bidalloc_pkg::RES_SHARED_FREE:  count_next = count_reg - 1'b1;
                default:                        count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_reg  <= 1'b1;
            width_reg    <= 4'd7;
            count_reg    <= '0;
            word_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == bidalloc_pkg::CFG_FEATURE_PRESENT)
            begin
                feature_reg <= cfg_data[0];
            end
            if (cfg_write && cfg_index == bidalloc_pkg::CFG_ID_WIDTH_M1)
            begin
                width_reg <= cfg_data;
            end
            count_reg    <= count_next;
            word_cnt_reg <= word_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mem_rd)
        begin
            rd_data_reg <= bitmap_mem[word_cnt_reg];
        end
        if (ctl.mem_wr)
        begin
            bitmap_mem[word_cnt_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_id)
        begin
            id_reg <= id;
        end
        if (ctl.mask_load)
        begin
            free_reg <= free_next;
            grp_reg  <= grp_next;
        end
        if (ctl.result_load)
        begin
            case (ctl.res_sel)
                bidalloc_pkg::RES_TRIVIAL:
                begin
                    status_reg             <= bidalloc_pkg::ST_OK;
                    result_id_reg          <= '0;
                    refresh_request_reg    <= 1'b0;
                    refresh_is_release_reg <= 1'b0;
                end
                bidalloc_pkg::RES_NO_FREE:
                begin
                    status_reg             <= bidalloc_pkg::ST_NO_FREE;
                    result_id_reg          <= '0;
                    refresh_request_reg    <= 1'b0;
                    refresh_is_release_reg <= 1'b0;
                end
                bidalloc_pkg::RES_SATURATED:
                begin
                    status_reg             <= bidalloc_pkg::ST_SATURATED;
                    result_id_reg          <= '0;
                    refresh_request_reg    <= 1'b0;
                    refresh_is_release_reg <= 1'b0;
                end
                bidalloc_pkg::RES_SHARED_ALLOC:
                begin
                    status_reg             <= bidalloc_pkg::ST_OK;
                    result_id_reg          <= SHARED_ID;
                    refresh_request_reg    <= (count_reg == '0);
                    refresh_is_release_reg <= 1'b0;
                end
                bidalloc_pkg::RES_SHARED_FREE:
                begin
                    // refresh only on the last release
                    status_reg             <= bidalloc_pkg::ST_OK;
                    result_id_reg          <= SHARED_ID;
                    refresh_request_reg    <= (count_reg == SHARED_COUNT_BITS'(1));
                    refresh_is_release_reg <= (count_reg == SHARED_COUNT_BITS'(1));
                end
                bidalloc_pkg::RES_PRIV_ALLOC:
                begin
                    status_reg             <= bidalloc_pkg::ST_OK;
                    result_id_reg          <= pick_id;
                    refresh_request_reg    <= 1'b1;
                    refresh_is_release_reg <= 1'b0;
                end
                bidalloc_pkg::RES_PRIV_FREE:
                begin
                    status_reg             <= bidalloc_pkg::ST_OK;
                    result_id_reg          <= id_reg;
                    refresh_request_reg    <= 1'b1;
                    refresh_is_release_reg <= 1'b1;
                end
                default:
                begin
                    status_reg             <= bidalloc_pkg::ST_INVALID;
                    result_id_reg          <= '0;
                    refresh_request_reg    <= 1'b0;
                    refresh_is_release_reg <= 1'b0;
                end
            endcase
        end
    end

    assign status             = status_reg;
    assign result_id          = result_id_reg;
    assign refresh_request    = refresh_request_reg;
    assign refresh_is_release = refresh_is_release_reg;

    assign stat.cmd_alloc_priv   = (command == bidalloc_pkg::CMD_ALLOC_PRIVATE);
    assign stat.cmd_alloc_shared = (command == bidalloc_pkg::CMD_ALLOC_SHARED);
    assign stat.cmd_free         = (command == bidalloc_pkg::CMD_FREE);
    assign stat.feature          = feature_reg;
    assign stat.shared_full      = &count_reg;
    assign stat.shared_zero      = (count_reg == '0);
    assign stat.id_is_shared     = (id == SHARED_ID);
    assign stat.id_in_range      = (id >= PRIV_START) && (id <= top);
    assign stat.found            = |grp_reg;
    assign stat.scan_last        = (word_cnt_reg == last_word);
    assign stat.init_last        = (word_cnt_reg == LAST_WORD);

endmodule

/* rtl/core/bidalloc_ctrl.sv */
// controller FSM: memory clearing pass, command dispatch, word scan, private free RMW
// depends on bidalloc_pkg
`timescale 1ns / 1ps

module bidalloc_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  bidalloc_pkg::ctl_stat_t  stat,
    output bidalloc_pkg::ctl_cmd_t   ctl,
    output logic                     busy,
    output logic                     result_valid
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_MASK,
        S_SCAN_PICK,
        S_FREE_RD,
        S_FREE_WR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = 1'b0;
        ctl.word_op       = bidalloc_pkg::WOP_HOLD;
        ctl.latch_id      = 1'b0;
        ctl.mem_rd        = 1'b0;
        ctl.mem_wr        = 1'b0;
        ctl.wr_sel        = bidalloc_pkg::WR_INIT;
        ctl.mask_load     = 1'b0;
        ctl.result_load   = 1'b0;
        ctl.res_sel       = bidalloc_pkg::RES_INVALID;

        case (state_reg)
            S_INIT:
            begin
                ctl.mem_wr = 1'b1;
                ctl.wr_sel = bidalloc_pkg::WR_INIT;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.word_op = bidalloc_pkg::WOP_INC;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (!(stat.cmd_alloc_priv || stat.cmd_alloc_shared || stat.cmd_free))
                    begin
                        ctl.result_load   = 1'b1;
                        ctl.res_sel       = bidalloc_pkg::RES_INVALID;
                        result_valid_next = 1'b1;
                    end
                    else if (!stat.feature)
                    begin
                        ctl.result_load   = 1'b1;
                        ctl.res_sel       = bidalloc_pkg::RES_TRIVIAL;
                        result_valid_next = 1'b1;
                    end
                    else if (stat.cmd_alloc_priv)
                    begin
                        ctl.word_op = bidalloc_pkg::WOP_CLEAR;
                        state_next  = S_SCAN_RD;
                    end
                    else if (stat.cmd_alloc_shared)
                    begin
                        ctl.result_load   = 1'b1;
                        ctl.res_sel       = stat.shared_full ? bidalloc_pkg::RES_SATURATED
                                                             : bidalloc_pkg::RES_SHARED_ALLOC;
                        result_valid_next = 1'b1;
                    end
                    else if (stat.id_is_shared)
                    begin
                        ctl.result_load   = 1'b1;
                        ctl.res_sel       = stat.shared_zero ? bidalloc_pkg::RES_INVALID
                                                             : bidalloc_pkg::RES_SHARED_FREE;
                        result_valid_next = 1'b1;
                    end
                    else if (stat.id_in_range)
                    begin
                        ctl.latch_id = 1'b1;
                        ctl.word_op  = bidalloc_pkg::WOP_FROM_ID;
                        state_next   = S_FREE_RD;
                    end
                    else
                    begin
                        ctl.result_load   = 1'b1;
                        ctl.res_sel       = bidalloc_pkg::RES_INVALID;
                        result_valid_next = 1'b1;
                    end
                end
            end
            S_SCAN_RD:
            begin
                ctl.mem_rd = 1'b1;
                state_next = S_SCAN_MASK;
            end
            S_SCAN_MASK:
            begin
                ctl.mask_load = 1'b1;
                state_next    = S_SCAN_PICK;
            end
            S_SCAN_PICK:
            begin
                if (stat.found)
                begin
                    ctl.mem_wr        = 1'b1;
                    ctl.wr_sel        = bidalloc_pkg::WR_SET;
                    ctl.result_load   = 1'b1;
                    ctl.res_sel       = bidalloc_pkg::RES_PRIV_ALLOC;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
                else if (stat.scan_last)
                begin
                    ctl.result_load   = 1'b1;
                    ctl.res_sel       = bidalloc_pkg::RES_NO_FREE;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    ctl.word_op = bidalloc_pkg::WOP_INC;
                    state_next  = S_SCAN_RD;
                end
            end
            S_FREE_RD:
            begin
                ctl.mem_rd = 1'b1;
                state_next = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                ctl.mem_wr        = 1'b1;
                ctl.wr_sel        = bidalloc_pkg::WR_CLR;
                ctl.result_load   = 1'b1;
                ctl.res_sel       = bidalloc_pkg::RES_PRIV_FREE;
                result_valid_next = 1'b1;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            busy_reg         <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            busy_reg         <= busy_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign busy         = busy_reg;
    assign result_valid = result_valid_reg;

endmodule

/* rtl/core/bitmap_id_allocator_shared_refcount_top.sv */
// top level of the context-id bitmap allocator with a use-counted shared id
// depends on bidalloc_pkg, bidalloc_ctrl, bidalloc_dp
`timescale 1ns / 1ps

// A command transfers at a clock edge with start high and busy low. Each command
// yields exactly one result, shown on the result ports for a single cycle with
// result_valid high; the receiver cannot stall it and must take it in that cycle.
// Invalid commands, feature-off commands, shared allocations and shared frees
// are answered from the idle state; a private free reads, modifies and writes back
// one bitmap word; a private allocation scans 64-bit bitmap words through one
// memory read port, each word through read, mask and pick steps, up to four words
// with 256 ids. After reset the bitmap memory is cleared one word a cycle, all
// ceil(MAX_IDS / 64) words, with busy high; config writes are taken throughout.

module bitmap_id_allocator_shared_refcount_top #(
    parameter int MAX_IDS           = bidalloc_pkg::DEF_MAX_IDS,
    parameter int RESERVED_COUNT    = bidalloc_pkg::DEF_RESERVED_COUNT,
    parameter int SHARED_COUNT_BITS = bidalloc_pkg::DEF_SHARED_COUNT_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [bidalloc_pkg::CMD_W-1:0]       command,
    input  logic [bidalloc_pkg::ID_W-1:0]        id,
    input  logic                                 cfg_write,
    input  logic [bidalloc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bidalloc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                 result_valid,
    output logic [bidalloc_pkg::STATUS_W-1:0]    status,
    output logic [bidalloc_pkg::ID_W-1:0]        result_id,
    output logic                                 refresh_request,
    output logic                                 refresh_is_release
);

    bidalloc_pkg::ctl_cmd_t  ctl;
    bidalloc_pkg::ctl_stat_t stat;

    bidalloc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .stat         (stat),
        .ctl          (ctl),
        .busy         (busy),
        .result_valid (result_valid)
    );

    bidalloc_dp #(
        .MAX_IDS           (MAX_IDS),
        .RESERVED_COUNT    (RESERVED_COUNT),
        .SHARED_COUNT_BITS (SHARED_COUNT_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .command            (command),
        .id                 (id),
        .ctl                (ctl),
        .stat               (stat),
        .status             (status),
        .result_id          (result_id),
        .refresh_request    (refresh_request),
        .refresh_is_release (refresh_is_release)
    );

endmodule

/* bench/testbench.sv */
// self-checking testbench for the context-id bitmap allocator with a shared use count
// depends on bidalloc_pkg and bitmap_id_allocator_shared_refcount_top
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_IDS           = bidalloc_pkg::DEF_MAX_IDS;
    localparam int RESERVED_COUNT    = bidalloc_pkg::DEF_RESERVED_COUNT;
    localparam int SHARED_COUNT_BITS = bidalloc_pkg::DEF_SHARED_COUNT_BITS;
    localparam int ID_W              = bidalloc_pkg::ID_W;
    localparam int CMD_W             = bidalloc_pkg::CMD_W;
    localparam int STATUS_W          = bidalloc_pkg::STATUS_W;
    localparam int CFG_IDX_W         = bidalloc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W        = bidalloc_pkg::CFG_DATA_W;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [ID_W-1:0]  SHARED_ID  = ID_W'(RESERVED_COUNT);
    localparam int               PRIV_START = RESERVED_COUNT + 1;
    localparam bit [63:0]        USE_MASK   = (SHARED_COUNT_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                              : ((64'd1 << SHARED_COUNT_BITS) - 64'd1);
    localparam int               SETTLE_CYCLES = 20;

    class refcount_scoreboard;
        typedef struct {
            logic [STATUS_W-1:0] status;
            logic [ID_W-1:0]     rid;
            logic                req;
            logic                rel;
        } outcome_t;

        bit        used [MAX_IDS];
        bit [63:0] shared_uses;
        bit        feature_on;
        bit [3:0]  width_m1;
        outcome_t  awaited [$];
        int        errors;

        function new();
            for (int i = 0; i < MAX_IDS; i++)
            begin
                used[i] = (i <= RESERVED_COUNT);
            end
            shared_uses = '0;
            feature_on  = 1'b1;
            width_m1    = 4'd7;
            errors      = 0;
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == bidalloc_pkg::CFG_FEATURE_PRESENT)
                feature_on = data[0];
            else if (idx == bidalloc_pkg::CFG_ID_WIDTH_M1)
                width_m1 = data[3:0];
        endfunction

        function int unsigned top_id();
            int unsigned t;
            t = (32'd1 << (width_m1 + 1)) - 1;
            if (t > MAX_IDS - 1)
                t = MAX_IDS - 1;
            return t;
        endfunction

        function void push(logic [STATUS_W-1:0] st, logic [ID_W-1:0] rid, logic req, logic rel);
            outcome_t o;
            o.status = st;
            o.rid    = rid;
            o.req    = req;
            o.rel    = rel;
            awaited.push_back(o);
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] idv);
            int unsigned top;
            bit [63:0]   uses;
            top  = top_id();
            uses = shared_uses & USE_MASK;
            if (cmd == CMD_UNUSED)
                push(bidalloc_pkg::ST_INVALID, '0, 1'b0, 1'b0);
            else if (!feature_on)
                push(bidalloc_pkg::ST_OK, '0, 1'b0, 1'b0);
            else if (cmd == bidalloc_pkg::CMD_ALLOC_PRIVATE)
            begin
                for (int k = PRIV_START; k <= top; k++)
                begin
                    if (!used[k])
                    begin
                        used[k] = 1'b1;
                        push(bidalloc_pkg::ST_OK, ID_W'(k), 1'b1, 1'b0);
                        return;
                    end
                end
                push(bidalloc_pkg::ST_NO_FREE, '0, 1'b0, 1'b0);
            end
            else if (cmd == bidalloc_pkg::CMD_ALLOC_SHARED)
            begin
                if (uses == USE_MASK)
                    push(bidalloc_pkg::ST_SATURATED, '0, 1'b0, 1'b0);
                else
                begin
                    shared_uses = (uses + 64'd1) & USE_MASK;
                    push(bidalloc_pkg::ST_OK, SHARED_ID, uses == 0, 1'b0);
                end
            end
            else if (idv == SHARED_ID)
            begin
                if (uses == 0)
                    push(bidalloc_pkg::ST_INVALID, '0, 1'b0, 1'b0);
                else
                begin
                    shared_uses = uses - 64'd1;
                    push(bidalloc_pkg::ST_OK, SHARED_ID, uses == 1, uses == 1);
                end
            end
            else if (idv < PRIV_START || idv > top)
                push(bidalloc_pkg::ST_INVALID, '0, 1'b0, 1'b0);
            else
            begin
                // cleared even when it was not held
                used[idv] = 1'b0;
                push(bidalloc_pkg::ST_OK, idv, 1'b1, 1'b1);
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic [ID_W-1:0] rid, logic req, logic rel);
            outcome_t e;
            if (awaited.size() == 0)
            begin
                report_mismatch("result with nothing expected");
                return;
            end
            e = awaited.pop_front();
            if (st !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
            if (rid !== e.rid)
                report_mismatch($sformatf("result_id %0d, expected %0d", rid, e.rid));
            if (req !== e.req)
                report_mismatch($sformatf("refresh_request %b, expected %b", req, e.req));
            if (rel !== e.rel)
                report_mismatch($sformatf("refresh_is_release %b, expected %b", rel, e.rel));
        endtask

        task check_leftovers();
            if (awaited.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", awaited.size()));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [CMD_W-1:0]      command;
    logic [ID_W-1:0]       id;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  result_valid;
    logic [STATUS_W-1:0]   status;
    logic [ID_W-1:0]       result_id;
    logic                  refresh_request;
    logic                  refresh_is_release;

    refcount_scoreboard sb = new();
    int burst_left = 0;

    bitmap_id_allocator_shared_refcount_top #(
        .MAX_IDS           (MAX_IDS),
        .RESERVED_COUNT    (RESERVED_COUNT),
        .SHARED_COUNT_BITS (SHARED_COUNT_BITS)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .command            (command),
        .id                 (id),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .result_valid       (result_valid),
        .status             (status),
        .result_id          (result_id),
        .refresh_request    (refresh_request),
        .refresh_is_release (refresh_is_release)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
            sb.check_result(status, result_id, refresh_request, refresh_is_release);
    end

    // one command transfer, then either stay in the burst or idle a while
    task transfer_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] idv);
        start   <= 1'b1;
        command <= cmd;
        id      <= idv;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_command(cmd, idv);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 0);
        end
    endtask

    task write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.configure(idx, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // block is idle once every result is in and the longest scan has had time to end
    task settle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [ID_W-1:0] pick_free_target();
        int unsigned top;
        int unsigned k;
        int          r;
        top = sb.top_id();
        r   = $urandom_range(99);
        k   = PRIV_START;
        if (r < 40 && top >= PRIV_START)
        begin
            // mostly ids that are actually held
            repeat (16)
            begin
                k = $urandom_range(top, PRIV_START);
                if (sb.used[k])
                    return ID_W'(k);
            end
            return ID_W'(k);
        end
        else if (r < 60)
            return SHARED_ID;
        else if (r < 80)
            return ID_W'($urandom_range(top + 3, 0));
        return ID_W'($urandom);
    endfunction

    task run_random(int n, int alloc_pct);
        int               r;
        logic [CMD_W-1:0] c;
        logic [ID_W-1:0]  v;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            v = ID_W'($urandom);
            if (r < alloc_pct)
                c = bidalloc_pkg::CMD_ALLOC_PRIVATE;
            else if (r < alloc_pct + 8)
                c = bidalloc_pkg::CMD_ALLOC_SHARED;
            else if (r < 98)
            begin
                c = bidalloc_pkg::CMD_FREE;
                v = pick_free_target();
            end
            else
                c = CMD_UNUSED;
            transfer_command(c, v);
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        command   <= bidalloc_pkg::CMD_ALLOC_PRIVATE;
        id        <= '0;
        cfg_write <= 1'b0;
        cfg_index <= bidalloc_pkg::CFG_FEATURE_PRESENT;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset settings
        transfer_command(CMD_UNUSED, 16'hFFFF);
        transfer_command(bidalloc_pkg::CMD_FREE, SHARED_ID);
        transfer_command(bidalloc_pkg::CMD_FREE, 16'd0);
        transfer_command(bidalloc_pkg::CMD_ALLOC_SHARED, 16'd0);
        transfer_command(bidalloc_pkg::CMD_ALLOC_SHARED, 16'hFFFF);
        transfer_command(bidalloc_pkg::CMD_FREE, SHARED_ID);
        transfer_command(bidalloc_pkg::CMD_FREE, SHARED_ID);
        transfer_command(bidalloc_pkg::CMD_ALLOC_PRIVATE, 16'hFFFF);
        transfer_command(bidalloc_pkg::CMD_ALLOC_PRIVATE, 16'd0);
        transfer_command(bidalloc_pkg::CMD_ALLOC_PRIVATE, 16'h5A5A);
        transfer_command(bidalloc_pkg::CMD_FREE, 16'd3);
        transfer_command(bidalloc_pkg::CMD_ALLOC_PRIVATE, 16'hA5A5);
        transfer_command(bidalloc_pkg::CMD_FREE, 16'd200);
        transfer_command(bidalloc_pkg::CMD_FREE, 16'd255);
        transfer_command(bidalloc_pkg::CMD_FREE, 16'd256);
        transfer_command(bidalloc_pkg::CMD_FREE, 16'hFFFF);
        settle();

        // narrowest width: the maximum id sits below the private range
        write_register(bidalloc_pkg::CFG_ID_WIDTH_M1, 4'd0);
        transfer_command(bidalloc_pkg::CMD_ALLOC_PRIVATE, 16'd0);
        transfer_command(bidalloc_pkg::CMD_FREE, 16'd2);
        transfer_command(bidalloc_pkg::CMD_FREE, SHARED_ID);
        transfer_command(bidalloc_pkg::CMD_ALLOC_SHARED, 16'd0);
        run_random(40, 40);
        settle();

        write_register(bidalloc_pkg::CFG_ID_WIDTH_M1, 4'd1);
        run_random(60, 60);
        settle();

        // fill the whole default range until allocation runs dry
        write_register(bidalloc_pkg::CFG_ID_WIDTH_M1, 4'd7);
        run_random(300, 88);
        settle();

        // shrink below ids still held
        write_register(bidalloc_pkg::CFG_ID_WIDTH_M1, 4'd2);
        run_random(80, 40);
        settle();

        // widest setting, clamped to the store size
        write_register(bidalloc_pkg::CFG_ID_WIDTH_M1, 4'd15);
        run_random(150, 50);
        settle();

        write_register(bidalloc_pkg::CFG_FEATURE_PRESENT, 4'd0);
        run_random(40, 40);
        settle();

        write_register(bidalloc_pkg::CFG_FEATURE_PRESENT, 4'd1);
        write_register(bidalloc_pkg::CFG_ID_WIDTH_M1, 4'd3);
        run_random(60, 50);
        settle();

        sb.check_leftovers();
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
